### hdl/hbs_pkg.sv
// ---------------------------------------------------------------------------
// hbs_pkg - shared types and constants of the heightmap bilinear sampler
// Configuration layout, register indexes, opcodes and fixed field widths.
// ---------------------------------------------------------------------------
package hbs_pkg;

   localparam int MAX_RES_DEF   = 512;
   localparam int FRAC_BITS_DEF = 16;

   // fixed field widths
   localparam int CODE_W  = 16;
   localparam int INDEX_W = 18;
   localparam int COORD_W = 32;
   localparam int OUT_W   = 41;
   localparam int CSR_IW  = 3;
   localparam int CSR_DW  = 32;

   // opcodes of an input word
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_IW-1:0] CSR_CENTER_X  = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_CENTER_Y  = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_HALF_SIDE = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_RES       = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_DATUM     = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_STEP      = 3'd5;

   localparam logic [30:0] HALF_SIDE_RST = 31'd3000000;

   // fixed base height, 51133 cm in q8
   localparam logic signed [43:0] BASE_CM_Q8 = 44'sd13090048;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic [30:0]        half_side;
      logic [9:0]         resolution;
      logic signed [31:0] datum_cm_q8;
      logic [31:0]        step_cm_q16;
   } cfg_type;

endpackage

### hdl/hbs_ram.sv
// ---------------------------------------------------------------------------
// hbs_ram - generic single-port RAM
// One access a cycle, write or read; read data registered and held between
// reads.
// ---------------------------------------------------------------------------
module hbs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             en,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/hbs_front.sv
// ---------------------------------------------------------------------------
// hbs_front - point mapping and cell split
// Clamps each coordinate into the square, scales it by the grid, and runs a
// bit-per-stage divider to get cell index and fraction, then row offsets.
// ---------------------------------------------------------------------------
module hbs_front
   import hbs_pkg::*;
#(
   parameter int MAX_RES   = MAX_RES_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int IW = $clog2(MAX_RES),
   localparam int AW = $clog2(MAX_RES * MAX_RES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  in_op,
   input  logic [INDEX_W-1:0]    in_index,
   input  logic [CODE_W-1:0]     in_value,
   input  logic signed [31:0]    in_qx,
   input  logic signed [31:0]    in_qy,
   output logic                  out_valid,
   input  logic                  out_take,
   output logic                  out_op,
   output logic [AW-1:0]         out_waddr,
   output logic                  out_wok,
   output logic [CODE_W-1:0]     out_wdata,
   output logic [IW-1:0]         out_x0,
   output logic [IW-1:0]         out_x1,
   output logic [AW-1:0]         out_row0,
   output logic [AW-1:0]         out_row1,
   output logic [FRAC_BITS-1:0]  out_tx,
   output logic [FRAC_BITS-1:0]  out_ty
);

   localparam int RW = $clog2(MAX_RES + 1);
   localparam int QW = IW + FRAC_BITS;
   localparam int NW = 32 + IW;
   localparam int NS = QW + 3;

   function automatic logic [31:0] clamp_axis(input logic signed [31:0] q,
                                              input logic signed [31:0] c,
                                              input logic [30:0] h,
                                              input logic [31:0] span);
      logic signed [33:0] d;
      d = 34'(q) - 34'(c) + $signed({3'b000, h});
      if (d[33]) begin
         return '0;
      end else if (d[32:0] > {1'b0, span}) begin
         return span;
      end else begin
         return d[31:0];
      end
   endfunction

   // one restoring step: shift in the next dividend bit, subtract if it fits
   function automatic logic [32+QW-1:0] div_step(input logic [31:0] r,
                                                 input logic [QW-1:0] ql,
                                                 input logic [31:0] d);
      logic [32:0] t;
      logic        ge;
      logic [31:0] rn;
      t  = {r, ql[QW-1]};
      ge = (t >= {1'b0, d});
      rn = ge ? 32'(t - {1'b0, d}) : t[31:0];
      return {rn, ql[QW-2:0], ge};
   endfunction

   logic              adv;
   logic [NS-1:0]     v_ff;
   logic              op_ff    [NS];
   logic [AW-1:0]     wa_ff    [NS];
   logic              wok_ff   [NS];
   logic [CODE_W-1:0] wd_ff    [NS];

   logic [31:0]       ux_ff, uy_ff;
   logic [NW-1:0]     nx_ff, ny_ff;
   logic [31:0]       rx_ff [QW];
   logic [31:0]       ry_ff [QW];
   logic [QW-1:0]     qx_ff [QW];
   logic [QW-1:0]     qy_ff [QW];
   logic [31:0]       rxi   [QW];
   logic [31:0]       ryi   [QW];
   logic [QW-1:0]     qxi   [QW];
   logic [QW-1:0]     qyi   [QW];
   logic [31:0]       rxn   [QW];
   logic [31:0]       ryn   [QW];
   logic [QW-1:0]     qxn   [QW];
   logic [QW-1:0]     qyn   [QW];

   logic [IW-1:0]        x0_ff, x1_ff;
   logic [AW-1:0]        row0_ff, row1_ff;
   logic [FRAC_BITS-1:0] tx_ff, ty_ff;

   logic [30:0]    h_eff;
   logic [31:0]    span;
   logic [RW-1:0]  res_eff;
   logic           grid_tiny;
   logic [IW-1:0]  rm1;
   logic [IW-1:0]  ix, iy, x0c, x1c, y0c, y1c;

   always_comb begin
      h_eff     = (cfg.half_side == '0) ? 31'd1 : cfg.half_side;
      span      = {h_eff, 1'b0};
      res_eff   = (int'(cfg.resolution) > MAX_RES) ? RW'(MAX_RES) : RW'(cfg.resolution);
      grid_tiny = (cfg.resolution <= 10'd1);
      rm1       = grid_tiny ? '0 : IW'(res_eff - RW'(1));

      for (int j = 0; j < QW; j++) begin
         if (j == 0) begin
            rxi[j] = nx_ff[NW-1:IW];
            ryi[j] = ny_ff[NW-1:IW];
            qxi[j] = {nx_ff[IW-1:0], {FRAC_BITS{1'b0}}};
            qyi[j] = {ny_ff[IW-1:0], {FRAC_BITS{1'b0}}};
         end else begin
            rxi[j] = rx_ff[j-1];
            ryi[j] = ry_ff[j-1];
            qxi[j] = qx_ff[j-1];
            qyi[j] = qy_ff[j-1];
         end
         {rxn[j], qxn[j]} = div_step(rxi[j], qxi[j], span);
         {ryn[j], qyn[j]} = div_step(ryi[j], qyi[j], span);
      end

      ix  = qx_ff[QW-1][QW-1:FRAC_BITS];
      iy  = qy_ff[QW-1][QW-1:FRAC_BITS];
      x0c = (ix > rm1) ? rm1 : ix;
      y0c = (iy > rm1) ? rm1 : iy;
      x1c = (x0c == rm1) ? x0c : x0c + IW'(1);
      y1c = (y0c == rm1) ? y0c : y0c + IW'(1);
   end

   assign adv      = !v_ff[NS-1] || out_take;
   assign in_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op_ff[0]  <= in_op;
         wa_ff[0]  <= AW'(in_index);
         wok_ff[0] <= (32'(in_index) < 32'(MAX_RES * MAX_RES));
         wd_ff[0]  <= in_value;
         for (int k = 1; k < NS; k++) begin
            op_ff[k]  <= op_ff[k-1];
            wa_ff[k]  <= wa_ff[k-1];
            wok_ff[k] <= wok_ff[k-1];
            wd_ff[k]  <= wd_ff[k-1];
         end
         ux_ff <= clamp_axis(in_qx, cfg.center_x, h_eff, span);
         uy_ff <= clamp_axis(in_qy, cfg.center_y, h_eff, span);
         nx_ff <= NW'(ux_ff) * NW'(rm1);
         ny_ff <= NW'(uy_ff) * NW'(rm1);
         for (int j = 0; j < QW; j++) begin
            rx_ff[j] <= rxn[j];
            ry_ff[j] <= ryn[j];
            qx_ff[j] <= qxn[j];
            qy_ff[j] <= qyn[j];
         end
         x0_ff   <= x0c;
         x1_ff   <= x1c;
         tx_ff   <= qx_ff[QW-1][FRAC_BITS-1:0];
         ty_ff   <= qy_ff[QW-1][FRAC_BITS-1:0];
         row0_ff <= AW'(AW'(y0c) * AW'(res_eff));
         row1_ff <= AW'(AW'(y1c) * AW'(res_eff));
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_op    = op_ff[NS-1];
   assign out_waddr = wa_ff[NS-1];
   assign out_wok   = wok_ff[NS-1];
   assign out_wdata = wd_ff[NS-1];
   assign out_x0    = x0_ff;
   assign out_x1    = x1_ff;
   assign out_row0  = row0_ff;
   assign out_row1  = row1_ff;
   assign out_tx    = tx_ff;
   assign out_ty    = ty_ff;

endmodule

### hdl/hbs_seq.sv
// ---------------------------------------------------------------------------
// hbs_seq - grid memory sequencer
// Owns the grid RAM: a load writes its word if its index is in range, a query
// reads its four neighbours in turn and gathers the codes for the interpolator.
// ---------------------------------------------------------------------------
module hbs_seq
   import hbs_pkg::*;
#(
   parameter int MAX_RES   = MAX_RES_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int IW = $clog2(MAX_RES),
   localparam int AW = $clog2(MAX_RES * MAX_RES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_take,
   input  logic                  in_op,
   input  logic [AW-1:0]         in_waddr,
   input  logic                  in_wok,
   input  logic [CODE_W-1:0]     in_wdata,
   input  logic [IW-1:0]         in_x0,
   input  logic [IW-1:0]         in_x1,
   input  logic [AW-1:0]         in_row0,
   input  logic [AW-1:0]         in_row1,
   input  logic [FRAC_BITS-1:0]  in_tx,
   input  logic [FRAC_BITS-1:0]  in_ty,
   input  logic                  back_ready,
   output logic                  out_valid,
   output logic [CODE_W-1:0]     out_c00,
   output logic [CODE_W-1:0]     out_c10,
   output logic [CODE_W-1:0]     out_c01,
   output logic [CODE_W-1:0]     out_c11,
   output logic [FRAC_BITS-1:0]  out_tx,
   output logic [FRAC_BITS-1:0]  out_ty
);

   typedef enum logic [1:0] {PH_00, PH_10, PH_01, PH_11} phase_type;

   logic                 sq_valid_ff;
   logic                 sq_op_ff;
   logic [AW-1:0]        sq_waddr_ff;
   logic                 sq_wok_ff;
   logic [CODE_W-1:0]    sq_wdata_ff;
   logic [IW-1:0]        sq_x0_ff, sq_x1_ff;
   logic [AW-1:0]        sq_row0_ff, sq_row1_ff;
   logic [FRAC_BITS-1:0] sq_tx_ff, sq_ty_ff;
   phase_type            ph_ff;
   logic                 rdv_ff;
   phase_type            rdph_ff;
   logic [CODE_W-1:0]    c00_ff, c10_ff, c01_ff;
   logic                 pd_valid_ff;
   logic [FRAC_BITS-1:0] pd_tx_ff, pd_ty_ff;

   logic                 is_load, issue, done;
   logic                 ram_en, ram_we;
   logic [AW-1:0]        ram_addr;
   logic [CODE_W-1:0]    ram_rdata;

   always_comb begin
      is_load = sq_valid_ff && (sq_op_ff == OP_LOAD);
      // a read may only go out once the held word can leave
      issue   = sq_valid_ff && (sq_op_ff == OP_QUERY) && (!pd_valid_ff || back_ready);
      done    = is_load || (issue && (ph_ff == PH_11));
      in_take = in_valid && (!sq_valid_ff || done);
      ram_en  = (is_load && sq_wok_ff) || issue;
      ram_we  = is_load;
      if (is_load) begin
         ram_addr = sq_waddr_ff;
      end else begin
         case (ph_ff)
            PH_00:   ram_addr = sq_row0_ff + AW'(sq_x0_ff);
            PH_10:   ram_addr = sq_row0_ff + AW'(sq_x1_ff);
            PH_01:   ram_addr = sq_row1_ff + AW'(sq_x0_ff);
            PH_11:   ram_addr = sq_row1_ff + AW'(sq_x1_ff);
            default: ram_addr = sq_row0_ff;
         endcase
      end
   end

   hbs_ram #(
      .WIDTH (CODE_W),
      .DEPTH (MAX_RES * MAX_RES)
   ) u_grid (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (sq_wdata_ff),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         ph_ff       <= PH_00;
         rdv_ff      <= 1'b0;
         rdph_ff     <= PH_00;
         pd_valid_ff <= 1'b0;
      end else begin
         if (in_take) begin
            sq_valid_ff <= 1'b1;
            sq_op_ff    <= in_op;
            sq_waddr_ff <= in_waddr;
            sq_wok_ff   <= in_wok;
            sq_wdata_ff <= in_wdata;
            sq_x0_ff    <= in_x0;
            sq_x1_ff    <= in_x1;
            sq_row0_ff  <= in_row0;
            sq_row1_ff  <= in_row1;
            sq_tx_ff    <= in_tx;
            sq_ty_ff    <= in_ty;
            ph_ff       <= PH_00;
         end else if (done) begin
            sq_valid_ff <= 1'b0;
         end else if (issue) begin
            case (ph_ff)
               PH_00:   ph_ff <= PH_10;
               PH_10:   ph_ff <= PH_01;
               PH_01:   ph_ff <= PH_11;
               default: ph_ff <= PH_00;
            endcase
         end

         // the last code is taken straight from the RAM output
         rdv_ff  <= issue && (ph_ff != PH_11);
         rdph_ff <= ph_ff;
         if (rdv_ff) begin
            case (rdph_ff)
               PH_00:   c00_ff <= ram_rdata;
               PH_10:   c10_ff <= ram_rdata;
               PH_01:   c01_ff <= ram_rdata;
               default: ;
            endcase
         end

         if (issue && (ph_ff == PH_11)) begin
            pd_valid_ff <= 1'b1;
            pd_tx_ff    <= sq_tx_ff;
            pd_ty_ff    <= sq_ty_ff;
         end else if (back_ready) begin
            pd_valid_ff <= 1'b0;
         end
      end
   end

   assign out_valid = pd_valid_ff;
   assign out_c00   = c00_ff;
   assign out_c10   = c10_ff;
   assign out_c01   = c01_ff;
   assign out_c11   = ram_rdata;
   assign out_tx    = pd_tx_ff;
   assign out_ty    = pd_ty_ff;

`ifndef ASSERT_OFF
   a_no_read_under_held: assert property (@(posedge clock) disable iff (reset)
      (pd_valid_ff && !back_ready) |-> !(ram_en && !ram_we))
      else $error("grid read issued while gathered codes are held");

   a_query_leaves_last: assert property (@(posedge clock) disable iff (reset)
      (in_take && sq_valid_ff && (sq_op_ff == OP_QUERY)) |-> (ph_ff == PH_11))
      else $error("query replaced before its fourth read");

   a_capture_owner: assert property (@(posedge clock) disable iff (reset)
      rdv_ff |-> (sq_valid_ff && (sq_op_ff == OP_QUERY)))
      else $error("code captured with no query in progress");
`endif

endmodule

### hdl/hbs_back.sv
// ---------------------------------------------------------------------------
// hbs_back - bilinear blend and height scaling
// Blends the four codes, scales by step, adds datum less the fixed base and
// saturates (zero when resolution is at most one); the last stage is the output register.
// ---------------------------------------------------------------------------
module hbs_back
   import hbs_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [CODE_W-1:0]       in_c00,
   input  logic [CODE_W-1:0]       in_c10,
   input  logic [CODE_W-1:0]       in_c01,
   input  logic [CODE_W-1:0]       in_c11,
   input  logic [FRAC_BITS-1:0]    in_tx,
   input  logic [FRAC_BITS-1:0]    in_ty,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [OUT_W-1:0] rsp_height_cm_q8
);

   localparam int F   = FRAC_BITS;
   localparam int MW  = CODE_W + F + 1;
   localparam int RW2 = MW + F + 1;
   localparam int CW  = CODE_W + F;
   localparam int PW  = CW + 16;
   localparam logic [F:0] ONE = (F+1)'(1) << F;
   localparam logic signed [43:0] HT_MAX = (44'sd1 <<< 40) - 44'sd1;
   localparam logic signed [43:0] HT_MIN = -(44'sd1 <<< 40);

   logic [6:0]     v_ff;
   logic           adv;
   logic [MW-1:0]  m00_ff, m10_ff, m01_ff, m11_ff;
   logic [MW-1:0]  a_ff, b_ff;
   logic [F-1:0]   ty1_ff, ty2_ff;
   logic [RW2-1:0] ra_ff, rb_ff;
   logic [CW-1:0]  code_ff;
   logic [PW-1:0]  hi_ff, lo_ff;
   logic [OUT_W-1:0] sc_ff;
   logic signed [OUT_W-1:0] ht_ff;

   logic [F:0]       wx0, wy0;
   logic [RW2-1:0]   rsum;
   logic [PW:0]      ssum;
   logic signed [43:0] ht;
   logic signed [OUT_W-1:0] ht_sat;

   always_comb begin
      wx0  = ONE - {1'b0, in_tx};
      wy0  = ONE - {1'b0, ty2_ff};
      rsum = ra_ff + rb_ff;
      ssum = (PW+1)'(hi_ff) + (PW+1)'(lo_ff >> 16);
      ht   = $signed({{12{cfg.datum_cm_q8[31]}}, cfg.datum_cm_q8})
           + $signed({3'b000, sc_ff}) - BASE_CM_Q8;
      if (ht > HT_MAX) begin
         ht_sat = OUT_W'(HT_MAX);
      end else if (ht < HT_MIN) begin
         ht_sat = OUT_W'(HT_MIN);
      end else begin
         ht_sat = OUT_W'(ht);
      end
   end

   // hold the whole chain while the output word is stalled
   assign adv      = !v_ff[6] || !rsp_stall;
   assign in_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m00_ff  <= MW'(in_c00) * MW'(wx0);
         m10_ff  <= MW'(in_c10) * MW'(in_tx);
         m01_ff  <= MW'(in_c01) * MW'(wx0);
         m11_ff  <= MW'(in_c11) * MW'(in_tx);
         ty1_ff  <= in_ty;
         a_ff    <= m00_ff + m10_ff;
         b_ff    <= m01_ff + m11_ff;
         ty2_ff  <= ty1_ff;
         ra_ff   <= RW2'(a_ff) * RW2'(wy0);
         rb_ff   <= RW2'(b_ff) * RW2'(ty2_ff);
         code_ff <= rsum[2*F+CODE_W-1:F];
         hi_ff   <= PW'(code_ff) * PW'(cfg.step_cm_q16[31:16]);
         lo_ff   <= PW'(code_ff) * PW'(cfg.step_cm_q16[15:0]);
         sc_ff   <= ssum[PW:F-8];
         ht_ff   <= (cfg.resolution <= 10'd1) ? '0 : ht_sat;
      end
   end

   assign rsp_valid        = v_ff[6];
   assign rsp_height_cm_q8 = ht_ff;

endmodule

### hdl/heightmap_bilinear_sampler.sv
// ---------------------------------------------------------------------------
// heightmap_bilinear_sampler - grid store with bilinear height lookup
// Load words fill the grid; query words return one interpolated height.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one word: op load writes sample_value at sample_index (an
//   index past the grid is dropped, no response); op query returns exactly
//   one rsp_height_cm_q8 word, in request order.
//   csr_write with csr_index/csr_data sets a register; write only when idle.
// Port use: a query holds the single grid RAM port for one read per neighbour
//   and the sequencer takes the next word only with its fourth read; a load
//   uses it for one write. Mapping, divider and blend are fully pipelined.
// Path: a query passes the clamp, scale and divider stages of the front end,
//   the reads of its four neighbours, then the blend pipeline.
// Reset: clears control and restores register defaults; grid contents are
//   undefined until loaded, and there is no clearing pass.
// Stall: rsp_stall freezes the blend pipeline and its output register; the
//   gathered codes wait in the sequencer, and the front end raises req_stall
//   whenever its last stage holds a word that the sequencer cannot take.
// ---------------------------------------------------------------------------
module heightmap_bilinear_sampler
   import hbs_pkg::*;
#(
   parameter int MAX_RES   = MAX_RES_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_op,
   input  logic [INDEX_W-1:0]      req_sample_index,
   input  logic [CODE_W-1:0]       req_sample_value,
   input  logic signed [COORD_W-1:0] req_query_x,
   input  logic signed [COORD_W-1:0] req_query_y,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [OUT_W-1:0] rsp_height_cm_q8,
   input  logic                    csr_write,
   input  logic [CSR_IW-1:0]       csr_index,
   input  logic [CSR_DW-1:0]       csr_data
);

   localparam int IW = $clog2(MAX_RES);
   localparam int AW = $clog2(MAX_RES * MAX_RES);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x    <= '0;
         cfg_ff.center_y    <= '0;
         cfg_ff.half_side   <= HALF_SIDE_RST;
         cfg_ff.resolution  <= '0;
         cfg_ff.datum_cm_q8 <= '0;
         cfg_ff.step_cm_q16 <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CENTER_X:  cfg_ff.center_x    <= csr_data;
            CSR_CENTER_Y:  cfg_ff.center_y    <= csr_data;
            CSR_HALF_SIDE: cfg_ff.half_side   <= csr_data[30:0];
            CSR_RES:       cfg_ff.resolution  <= csr_data[9:0];
            CSR_DATUM:     cfg_ff.datum_cm_q8 <= csr_data;
            CSR_STEP:      cfg_ff.step_cm_q16 <= csr_data;
            default:       ;
         endcase
      end
   end

   logic                 fr_ready, fr_valid, fr_take, fr_op, fr_wok;
   logic [AW-1:0]        fr_waddr, fr_row0, fr_row1;
   logic [CODE_W-1:0]    fr_wdata;
   logic [IW-1:0]        fr_x0, fr_x1;
   logic [FRAC_BITS-1:0] fr_tx, fr_ty;

   logic                 sq_valid, bk_ready;
   logic [CODE_W-1:0]    sq_c00, sq_c10, sq_c01, sq_c11;
   logic [FRAC_BITS-1:0] sq_tx, sq_ty;

   hbs_front #(
      .MAX_RES   (MAX_RES),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (fr_ready),
      .in_op     (req_op),
      .in_index  (req_sample_index),
      .in_value  (req_sample_value),
      .in_qx     (req_query_x),
      .in_qy     (req_query_y),
      .out_valid (fr_valid),
      .out_take  (fr_take),
      .out_op    (fr_op),
      .out_waddr (fr_waddr),
      .out_wok   (fr_wok),
      .out_wdata (fr_wdata),
      .out_x0    (fr_x0),
      .out_x1    (fr_x1),
      .out_row0  (fr_row0),
      .out_row1  (fr_row1),
      .out_tx    (fr_tx),
      .out_ty    (fr_ty)
   );

   assign req_stall = !fr_ready;

   hbs_seq #(
      .MAX_RES   (MAX_RES),
      .FRAC_BITS (FRAC_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (fr_valid),
      .in_take    (fr_take),
      .in_op      (fr_op),
      .in_waddr   (fr_waddr),
      .in_wok     (fr_wok),
      .in_wdata   (fr_wdata),
      .in_x0      (fr_x0),
      .in_x1      (fr_x1),
      .in_row0    (fr_row0),
      .in_row1    (fr_row1),
      .in_tx      (fr_tx),
      .in_ty      (fr_ty),
      .back_ready (bk_ready),
      .out_valid  (sq_valid),
      .out_c00    (sq_c00),
      .out_c10    (sq_c10),
      .out_c01    (sq_c01),
      .out_c11    (sq_c11),
      .out_tx     (sq_tx),
      .out_ty     (sq_ty)
   );

   hbs_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .in_valid         (sq_valid),
      .in_ready         (bk_ready),
      .in_c00           (sq_c00),
      .in_c10           (sq_c10),
      .in_c01           (sq_c01),
      .in_c11           (sq_c11),
      .in_tx            (sq_tx),
      .in_ty            (sq_ty),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_height_cm_q8 (rsp_height_cm_q8)
   );

endmodule
